// ===== hdl/tae_pkg.sv =====
// ----------------------------------------------------------------------------
// Thermistor ADC emulator package
// Shared constants and the command and status structs of the block.
// ----------------------------------------------------------------------------
package tae_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_TEMP = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] CFG_FAULT = 2'd0;
    localparam logic [1:0] CFG_OVS   = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    localparam logic [2:0] FM_SHORT   = 3'd1;
    localparam logic [2:0] FM_OPEN    = 3'd2;
    localparam logic [2:0] FM_PULLUP  = 3'd3;
    localparam logic [2:0] FM_FERRITE = 3'd4;
    localparam logic [2:0] FM_BOTH    = 3'd5;

    localparam logic [12:0] MV_FULL = 13'd5000;
    // floor(44740*4700*65536/49440)
    localparam logic [63:0] R_UPPER_Q16 = 64'((64'd44740 * 64'd4700 * 64'd65536) / 64'd49440);

    // Command from the controller to the datapath.
    typedef struct packed {
        logic start_read;  // begin a read: latch setup, index zero
        logic fetch;       // issue table read at current index
        logic check;       // compare fetched entry
        logic interp;      // start interpolation divide
        logic scale;       // start scaling (not driven by the controller nor used by the datapath)
        logic finish;      // walk ended with no match: flag out of range
    } cmd_t;

    typedef struct packed {
        logic hit;         // fetched entry is at or below temperature
        logic last;        // index reached count
        logic div_busy;    // arithmetic sequence running
    } stat_t;

endpackage

// ===== hdl/tae_datapath.sv =====
// ----------------------------------------------------------------------------
// Thermistor ADC emulator datapath
// Table memory, walk index, shared serial divider and the scaling sequence.
// ----------------------------------------------------------------------------
module tae_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load_en,
    input  logic [5:0]            load_idx,
    input  logic [14:0]           load_code,
    input  logic signed [10:0]    load_temp,
    input  logic                  temp_en,
    input  logic [17:0]           temp_val,
    input  logic [2:0]            fault_mode,
    input  logic [6:0]            oversampling,
    input  logic [6:0]            entry_count,
    input  tae_pkg::cmd_t         cmd,
    output tae_pkg::stat_t        stat,
    output logic [12:0]           res_mv,
    output logic                  res_oor
);

    logic [14:0]        code_mem [tae_pkg::TABLE_DEPTH];
    logic signed [10:0] temp_mem [tae_pkg::TABLE_DEPTH];
    logic [14:0]        rd_code_reg, prev_code_reg;
    logic signed [10:0] rd_temp_reg, prev_temp_reg;
    logic [17:0]        cur_reg;
    logic [tae_pkg::CNT_W-1:0] idx_reg, count_reg;
    logic [6:0]         div_reg;
    logic [2:0]         mode_reg;

    always_ff @(posedge aclk) begin
        if (load_en && (32'(load_idx) < tae_pkg::TABLE_DEPTH)) begin
            code_mem[load_idx[tae_pkg::IDX_W-1:0]] <= load_code;
            temp_mem[load_idx[tae_pkg::IDX_W-1:0]] <= load_temp;
        end
        if (cmd.fetch) begin
            rd_code_reg <= code_mem[idx_reg[tae_pkg::IDX_W-1:0]];
            rd_temp_reg <= temp_mem[idx_reg[tae_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else if (temp_en) begin
            cur_reg <= temp_val;
        end
    end

    logic signed [20:0] ti_w;
    logic signed [20:0] tp_w;
    assign ti_w = 21'(rd_temp_reg) <<< 8;
    assign tp_w = 21'(prev_temp_reg) <<< 8;
    assign stat.hit  = ti_w <= $signed({3'b0, cur_reg});
    assign stat.last = idx_reg >= count_reg;

    // Serial signed-magnitude divider: 64-bit numerator, 64-bit denominator.
    logic [63:0] num_reg, den_reg, quo_reg;
    logic [64:0] rem_reg;
    logic [6:0]  bit_reg;
    logic        busy_reg, neg_reg;
    // Sequence step: 0 interp, 1 ovs, 2 rth, 3 vx, 4 vpull
    logic [2:0]  step_reg;
    localparam logic [2:0] ST_INT = 3'd0, ST_OVS = 3'd1, ST_RTH = 3'd2,
                           ST_VX = 3'd3, ST_VP = 3'd4;
    logic        seq_reg;
    logic [63:0] vx_reg;
    logic [16:0] pu_reg;
    logic [12:0] mv_reg;
    logic        oor_reg;
    logic        exact_reg;

    logic [64:0] rem_sh;
    assign rem_sh = {rem_reg[63:0], num_reg[63]};

    // Mult registers: product before the interpolation divide.
    logic signed [36:0] prod_a_reg, prod_b_reg;
    logic signed [47:0] numi_w;
    logic signed [22:0] dt_w, d_w;
    logic signed [15:0] dadc_w;
    assign dt_w   = 23'(ti_w) - 23'(tp_w);
    assign d_w    = 23'($signed({3'b0, cur_reg})) - 23'(ti_w);
    assign dadc_w = $signed({1'b0, rd_code_reg}) - $signed({1'b0, prev_code_reg});
    assign numi_w = 48'(prod_a_reg) + 48'(prod_b_reg);

    task automatic start_div(input logic [63:0] n, input logic [63:0] d, input logic ng);
        num_reg  <= n;
        den_reg  <= d;
        rem_reg  <= '0;
        quo_reg  <= '0;
        bit_reg  <= 7'd64;
        busy_reg <= 1'b1;
        neg_reg  <= ng;
    endtask

    logic [63:0] q_w;
    assign q_w = quo_reg;
    logic [63:0] mvn_w;

    // The two constant divisors use reciprocal multiplication.
    // floor(u * 5000 / 1023) for u up to 1023.
    logic [33:0] lin_w;
    assign lin_w = 34'(q_w[10:0]) * 34'd5125005;
    // floor((327680 - Vx) * 4740 / 44740), computed as (327680 - Vx) * 237 / 2237.
    logic [19:0] pu_y_w;
    logic [47:0] pu_prod_w;
    assign pu_y_w    = 20'(64'd327680 - q_w);
    assign pu_prod_w = 48'(pu_y_w) * 48'd227516149;

    always_comb begin
        mvn_w = '0;
        if (mode_reg == tae_pkg::FM_PULLUP || mode_reg == tae_pkg::FM_BOTH)
            mvn_w = ((vx_reg + 64'(pu_reg)) * 64'd1000) >> 16;
        else
            mvn_w = (vx_reg * 64'd1000) >> 16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            seq_reg  <= 1'b0;
            idx_reg  <= '0;
        end else begin
            if (cmd.start_read) begin
                idx_reg   <= '0;
                count_reg <= (entry_count > 7'(tae_pkg::TABLE_DEPTH)) ?
                             tae_pkg::CNT_W'(tae_pkg::TABLE_DEPTH) :
                             tae_pkg::CNT_W'(entry_count);
                div_reg   <= (oversampling == 7'd0) ? 7'd1 : oversampling;
                mode_reg  <= fault_mode;
                oor_reg   <= 1'b0;
                mv_reg    <= '0;
            end
            if (cmd.check && !stat.hit) begin
                prev_code_reg <= rd_code_reg;
                prev_temp_reg <= rd_temp_reg;
                idx_reg       <= idx_reg + 1'b1;
            end
            if (cmd.finish && stat.last) begin
                oor_reg <= 1'b1;
                mv_reg  <= '0;
            end
            if (cmd.check && stat.hit) begin
                prod_a_reg <= 37'($signed({1'b0, rd_code_reg}) * dt_w);
                prod_b_reg <= 37'(dadc_w * d_w);
                exact_reg  <= (idx_reg == '0) || (ti_w == $signed({3'b0, cur_reg}));
            end
            if (cmd.interp) begin
                seq_reg  <= 1'b1;
                step_reg <= ST_INT;
                if (exact_reg) begin
                    start_div(64'(rd_code_reg), 64'd1, 1'b0);
                end else begin
                    // dt is negative; divide magnitudes and fix sign.
                    start_div(numi_w[47] ? 64'(-numi_w) : 64'(numi_w),
                              64'(-dt_w), ~numi_w[47]);
                end
            end
            if (busy_reg) begin
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                num_reg <= {num_reg[62:0], 1'b0};
                bit_reg <= bit_reg - 1'b1;
                if (bit_reg == 7'd1) busy_reg <= 1'b0;
            end else if (seq_reg) begin
                case (step_reg)
                    ST_INT: begin
                        // neg result clamps to zero (truncation gives -q)
                        step_reg <= ST_OVS;
                        start_div((neg_reg && q_w != '0) ? 64'd0 : q_w,
                                  64'(div_reg), 1'b0);
                    end
                    ST_OVS: begin
                        if (mode_reg >= tae_pkg::FM_PULLUP && mode_reg <= tae_pkg::FM_BOTH) begin
                            if (q_w >= 64'd1023) begin
                                mv_reg  <= tae_pkg::MV_FULL;
                                seq_reg <= 1'b0;
                            end else begin
                                step_reg <= ST_RTH;
                                start_div(64'd4700 * q_w * 64'd65536,
                                          64'd1023 - q_w, 1'b0);
                            end
                        end else begin
                            // Anything above 1023 scales past full scale.
                            mv_reg  <= (q_w > 64'd1023) ? tae_pkg::MV_FULL : lin_w[32:20];
                            seq_reg <= 1'b0;
                        end
                    end
                    ST_RTH: begin
                        step_reg <= ST_VX;
                        start_div(64'd327680 * ((mode_reg == tae_pkg::FM_FERRITE ||
                                     mode_reg == tae_pkg::FM_BOTH) ?
                                    q_w + 64'd42598400 : q_w),
                                  tae_pkg::R_UPPER_Q16 + ((mode_reg == tae_pkg::FM_FERRITE ||
                                     mode_reg == tae_pkg::FM_BOTH) ?
                                    q_w + 64'd42598400 : q_w), 1'b0);
                    end
                    ST_VX: begin
                        vx_reg   <= q_w;
                        pu_reg   <= pu_prod_w[47:31];
                        step_reg <= ST_VP;
                    end
                    default: begin
                        // vx_reg holds Vx; pu_reg holds the pullup term.
                        mv_reg  <= (mvn_w > 64'd5000) ? tae_pkg::MV_FULL : mvn_w[12:0];
                        seq_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign stat.div_busy = busy_reg || seq_reg || cmd.interp;
    assign res_mv  = mv_reg;
    assign res_oor = oor_reg;

endmodule

// ===== hdl/tae_ctrl.sv =====
// ----------------------------------------------------------------------------
// Thermistor ADC emulator controller
// Sequences a read: table walk, arithmetic, result hand-off.
// ----------------------------------------------------------------------------
module tae_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [1:0]      kind,
    input  logic [2:0]      fault_mode,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [12:0]     m_mv,
    output logic            m_oor,
    input  logic [12:0]     res_mv,
    input  logic            res_oor,
    output tae_pkg::cmd_t   cmd,
    input  tae_pkg::stat_t  stat
);

    localparam logic [2:0] S_IDLE = 3'd0, S_FETCH = 3'd1, S_WAIT = 3'd2,
                           S_CHECK = 3'd3, S_INTERP = 3'd4, S_ARITH = 3'd5,
                           S_DONE = 3'd6, S_SETTLE = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       vld_reg;
    logic       force_reg;
    logic [12:0] fmv_reg;

    logic accept;
    assign s_tready = (state_reg == S_IDLE) && !vld_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && kind == tae_pkg::KIND_READ &&
                    fault_mode != tae_pkg::FM_SHORT && fault_mode != tae_pkg::FM_OPEN) begin
                    cmd.start_read = 1'b1;
                    state_next     = S_FETCH;
                end
            end
            S_FETCH: begin
                if (stat.last) begin
                    cmd.finish = 1'b1;
                    state_next = S_SETTLE;
                end else begin
                    cmd.fetch  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:  state_next = S_CHECK;
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = stat.hit ? S_INTERP : S_FETCH;
            end
            S_INTERP: begin
                cmd.interp = 1'b1;
                state_next = S_ARITH;
            end
            S_ARITH: if (!stat.div_busy) state_next = S_DONE;
            S_SETTLE: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
            force_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) vld_reg <= 1'b0;
            if (accept && kind == tae_pkg::KIND_READ &&
                (fault_mode == tae_pkg::FM_SHORT || fault_mode == tae_pkg::FM_OPEN)) begin
                vld_reg   <= 1'b1;
                force_reg <= 1'b1;
                fmv_reg   <= (fault_mode == tae_pkg::FM_OPEN) ? tae_pkg::MV_FULL : 13'd0;
            end
            if (state_reg == S_DONE) begin
                vld_reg   <= 1'b1;
                force_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = vld_reg;
    assign m_mv     = force_reg ? fmv_reg : res_mv;
    assign m_oor    = force_reg ? 1'b0 : res_oor;

endmodule

// ===== hdl/thermistor_adc_emulator_top.sv =====
// ----------------------------------------------------------------------------
// Thermistor ADC emulator
// Table lookup with linear interpolation and fault-mode divider math.
// ----------------------------------------------------------------------------
// The s_ channel takes one word per command: load a table entry, set the
// temperature, or request a reading. Loads and temperature sets return
// nothing. A read returns one word on the m_ channel with the millivolt
// value and the out-of-range flag.
// A read walks the table entry by entry (memory read, register, compare),
// then runs divisions on one shared serial divider: two in the normal
// modes and four in the pullup and ferrite fault modes (two when the
// oversampled code saturates). Shorted and open faults answer without a
// table walk.
// Only one word is in flight: the input is not ready while a read runs or
// its result waits on the output register.
// When the receiver stalls, the result holds on m_tdata until taken.
// Reset (aresetn low, synchronous) clears the temperature, the registers to
// fault mode 0, oversampling 1, entry count 0, and the controller state.
// The table is not cleared; entries must be loaded before use. The user must
// write configuration (cfg_we, cfg_addr, cfg_wdata) idle only; not enforced.
// ----------------------------------------------------------------------------
module thermistor_adc_emulator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind[1:0], entry_index[7:2], entry_adc_code[22:8], entry_temp[33:23],
    // temperature[51:34], zero fill to 56 bits.
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // millivolts[12:0], out_of_range[13], zero fill to 16 bits.
    output logic [15:0] m_tdata
);

    logic [2:0] fault_reg;
    logic [6:0] ovs_reg, count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg <= '0;
            ovs_reg   <= 7'd1;
            count_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                tae_pkg::CFG_FAULT: fault_reg <= cfg_wdata[2:0];
                tae_pkg::CFG_OVS:   ovs_reg   <= cfg_wdata;
                tae_pkg::CFG_COUNT: count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tae_pkg::cmd_t  cmd;
    tae_pkg::stat_t stat;
    logic [12:0] res_mv, m_mv;
    logic        res_oor, m_oor;
    logic        acc;
    assign acc = s_tvalid && s_tready;

    tae_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .load_en(acc && s_tdata[1:0] == tae_pkg::KIND_LOAD),
        .load_idx(s_tdata[7:2]), .load_code(s_tdata[22:8]),
        .load_temp($signed(s_tdata[33:23])),
        .temp_en(acc && s_tdata[1:0] == tae_pkg::KIND_TEMP),
        .temp_val(s_tdata[51:34]),
        .fault_mode(fault_reg), .oversampling(ovs_reg), .entry_count(count_reg),
        .cmd(cmd), .stat(stat), .res_mv(res_mv), .res_oor(res_oor)
    );

    tae_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .kind(s_tdata[1:0]),
        .fault_mode(fault_reg), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_mv(m_mv), .m_oor(m_oor), .res_mv(res_mv), .res_oor(res_oor),
        .cmd(cmd), .stat(stat)
    );

    assign m_tdata = {2'b00, m_oor, m_mv};

endmodule

// ===== hdl/tae_checker.sv =====
// ----------------------------------------------------------------------------
// Thermistor ADC emulator checker
// Port-level properties of the result channel and of input ready.
// ----------------------------------------------------------------------------
module tae_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[12:0] <= 13'd5000)
        else $error("millivolts above full scale");

    a_oor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13] |-> m_tdata[12:0] == 13'd0)
        else $error("out of range with nonzero voltage");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result waits");

endmodule

bind thermistor_adc_emulator_top tae_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
